// ===== rtl/rbf_svm_pkg.sv =====
// ----------------------------------------------------------------------------
// RBF SVM package
// Shared types, constants and the exp table for the one-vs-one classifier.
// ----------------------------------------------------------------------------
package rbf_svm_pkg;

  localparam int unsigned MaxSvDef       = 64;
  localparam int unsigned MaxFeaturesDef = 16;
  localparam int unsigned MaxClassesDef  = 8;
  localparam int unsigned ExpEntriesDef  = 1024;

  typedef enum logic [2:0] {
    OP_SV     = 3'd0,
    OP_COEF   = 3'd1,
    OP_ICPT   = 3'd2,
    OP_CSTART = 3'd3,
    OP_FEAT   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    REG_GAMMA  = 2'd0,
    REG_SV_CNT = 2'd1,
    REG_FT_CNT = 2'd2,
    REG_CL_CNT = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         row_index;
    logic [5:0]         column_index;
    logic signed [15:0] value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         pair_index;
    logic signed [31:0] pair_score;
    logic [2:0]         predicted_class;
    logic [2:0]         vote_count;
    logic               end_of_run;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST_RD,
    ST_DIST_ACC,
    ST_KERN_MUL,
    ST_KERN_IDX,
    ST_KERN_WR,
    ST_PAIR_START,
    ST_PAIR_RD,
    ST_PAIR_MAC,
    ST_PAIR_EMIT,
    ST_FINAL_SCAN,
    ST_FINAL_EMIT
  } state_e;

  // exp(-i/64) in Q1.15, built as a chain of rounded Q32.32 products
  function automatic logic [15:0] exp_entry(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] prod_hi;
    logic [63:0] prod_lo;
    logic [63:0] acc_hi;
    logic [63:0] acc_lo;
    acc = 64'd1 << 32;
    for (int unsigned k = 0; k < idx; k++) begin
      acc_hi  = acc >> 16;
      acc_lo  = acc & 64'hFFFF;
      prod_hi = acc_hi * 64'd4228380000;
      prod_lo = acc_lo * 64'd4228380000 + (64'd1 << 31);
      acc     = (prod_hi + (prod_lo >> 16)) >> 16;
    end
    return 16'((acc + (64'd1 << 16)) >> 17);
  endfunction

endpackage

// ===== rtl/rbf_svm_exp_rom.sv =====
// ----------------------------------------------------------------------------
// RBF SVM exp table
// Registered read of exp(-i/64) in Q1.15; out-of-range indexes read zero.
// ----------------------------------------------------------------------------
module rbf_svm_exp_rom #(
  parameter int unsigned EXP_ENTRIES = rbf_svm_pkg::ExpEntriesDef
) (
  input  logic                           clk_i,
  input  logic [$clog2(EXP_ENTRIES)-1:0] addr_i,
  input  logic                           in_range_i,
  output logic [15:0]                    data_o
);
  import rbf_svm_pkg::*;

  logic [15:0] rom [EXP_ENTRIES];

  // Build the table from the rounding chain at elaboration
  for (genvar g = 0; g < EXP_ENTRIES; g++) begin : g_rom
    assign rom[g] = exp_entry(g);
  end

  // Register the read
  always_ff @(posedge clk_i) begin
    data_o <= in_range_i ? rom[addr_i] : 16'd0;
  end

endmodule

// ===== rtl/rbf_svm_ovo_classifier_top.sv =====
// ----------------------------------------------------------------------------
// RBF SVM one-vs-one classifier
// Load items fill the stores; the last feature item runs a classification.
// ----------------------------------------------------------------------------
// Load and plain feature items are taken one per cycle and give no result.
// A last feature item holds the input while the kernels are built, then while
// each pair's score is summed over the support vectors in its two class ranges
// and emitted, then while the vote is taken; a stalled result holds it longer.
// Results leave through one output register, which holds a result while stalled.
// Reset clears control and sets the configuration defaults; the memories are undefined until written.
module rbf_svm_ovo_classifier_top #(
  parameter int unsigned MAX_SV       = rbf_svm_pkg::MaxSvDef,
  parameter int unsigned MAX_FEATURES = rbf_svm_pkg::MaxFeaturesDef,
  parameter int unsigned MAX_CLASSES  = rbf_svm_pkg::MaxClassesDef,
  parameter int unsigned EXP_ENTRIES  = rbf_svm_pkg::ExpEntriesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rbf_svm_pkg::in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rbf_svm_pkg::out_req_t out_req_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import rbf_svm_pkg::*;

  localparam int unsigned SvW   = $clog2(MAX_SV);
  localparam int unsigned SvCW  = $clog2(MAX_SV + 1);
  localparam int unsigned FtW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned FtCW  = $clog2(MAX_FEATURES + 1);
  localparam int unsigned ClW   = $clog2(MAX_CLASSES);
  localparam int unsigned ClCW  = $clog2(MAX_CLASSES + 1);
  localparam int unsigned Pairs = MAX_CLASSES * (MAX_CLASSES - 1) / 2;
  localparam int unsigned PrW   = $clog2(Pairs + 1);
  localparam int unsigned PrIW  = (Pairs > 1) ? $clog2(Pairs) : 1;
  localparam int unsigned CoefW = $clog2((MAX_CLASSES - 1) * MAX_SV);
  localparam int unsigned SvmW  = $clog2(MAX_SV * MAX_FEATURES);
  localparam int unsigned ExpW  = $clog2(EXP_ENTRIES);
  localparam int unsigned DistW = 33 + FtCW;
  localparam int unsigned ProdW = DistW + 16;

  // Configuration registers
  logic [15:0] gamma_q;
  logic [6:0]  sv_cnt_q;
  logic [4:0]  ft_cnt_q;
  logic [3:0]  cl_cnt_q;

  // Memories
  logic signed [15:0] sv_mem   [MAX_SV * MAX_FEATURES];
  logic signed [15:0] coef_mem [(MAX_CLASSES - 1) * MAX_SV];
  logic signed [15:0] icpt_mem [Pairs];
  logic [6:0]         cst_mem  [MAX_CLASSES + 1];
  logic signed [15:0] feat_mem [MAX_FEATURES];
  logic [15:0]        kern_mem [MAX_SV];
  logic [2:0]         votes_q  [MAX_CLASSES];

  state_e state_q, state_d;

  logic [SvCW-1:0] ns;
  logic [FtCW-1:0] nf;
  logic [ClCW-1:0] nc;

  // Clamp counts to the built maxima
  assign ns = (32'(sv_cnt_q) > MAX_SV) ? SvCW'(MAX_SV) : SvCW'(sv_cnt_q);
  assign nf = (32'(ft_cnt_q) > MAX_FEATURES) ? FtCW'(MAX_FEATURES) : FtCW'(ft_cnt_q);
  assign nc = (32'(cl_cnt_q) > MAX_CLASSES) ? ClCW'(MAX_CLASSES) : ClCW'(cl_cnt_q);

  // Sequencer registers
  logic [SvCW-1:0]        s_q;
  logic [FtCW-1:0]        f_q;
  logic [DistW-1:0]       dist_q;
  logic [ProdW-1:0]       prod_q;
  logic [ClCW-1:0]        m_q, n_q, best_q;
  logic [PrW-1:0]         p_q;
  logic                   side_q;
  logic [SvCW-1:0]        lim_q;
  logic signed [47:0]     acc_q;
  logic signed [15:0]     sv_rd_q, coef_rd_q;
  logic [15:0]            kern_rd_q;

  out_req_t out_q;
  logic     out_vld_q;
  logic     out_free;
  logic     emit;
  assign out_free = !out_vld_q || !out_stall_i;
  assign emit     = out_free && (state_q == ST_PAIR_EMIT || state_q == ST_FINAL_EMIT);

  logic in_acc;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q  <= 16'd4096;
      sv_cnt_q <= 7'd64;
      ft_cnt_q <= 5'd16;
      cl_cnt_q <= 4'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAMMA:  gamma_q  <= cfg_data_i;
        REG_SV_CNT: sv_cnt_q <= cfg_data_i[6:0];
        REG_FT_CNT: ft_cnt_q <= cfg_data_i[4:0];
        REG_CL_CNT: cl_cnt_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Load writes
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (in_req_i.opcode)
        OP_SV: if (32'(in_req_i.row_index) < MAX_SV &&
                   32'(in_req_i.column_index) < MAX_FEATURES)
          sv_mem[SvmW'(32'(in_req_i.row_index) * MAX_FEATURES +
                       32'(in_req_i.column_index))] <= in_req_i.value;
        OP_COEF: if (32'(in_req_i.row_index) < MAX_CLASSES - 1 &&
                     32'(in_req_i.column_index) < MAX_SV)
          coef_mem[CoefW'(32'(in_req_i.row_index) * MAX_SV +
                          32'(in_req_i.column_index))] <= in_req_i.value;
        OP_ICPT: if (32'(in_req_i.row_index) < Pairs)
          icpt_mem[PrIW'(in_req_i.row_index)] <= in_req_i.value;
        OP_CSTART: if (32'(in_req_i.row_index) <= MAX_CLASSES)
          cst_mem[ClCW'(in_req_i.row_index)] <= in_req_i.value[6:0];
        OP_FEAT: if (32'(in_req_i.column_index) < MAX_FEATURES)
          feat_mem[FtW'(in_req_i.column_index)] <= in_req_i.value;
        default: ;
      endcase
    end
  end

  // Clamped class-start lookup for the current pair side
  logic [ClCW-1:0] cls_lo;
  logic [6:0]      cs0, cs1;
  logic [SvCW-1:0] c0, c1;
  assign cls_lo = side_q ? n_q : m_q;
  assign cs0    = cst_mem[cls_lo];
  assign cs1    = cst_mem[cls_lo + 1'b1];
  assign c0     = (32'(cs0) > 32'(ns)) ? ns : SvCW'(cs0);
  assign c1     = (32'(cs1) > 32'(ns)) ? ns : SvCW'(cs1);

  // Coefficient row: class n-1 on the m side, class m on the n side
  logic [ClCW-1:0] coef_row;
  assign coef_row = side_q ? m_q : n_q - 1'b1;

  // Registered memory reads
  always_ff @(posedge clk_i) begin
    sv_rd_q   <= sv_mem[SvmW'(32'(s_q) * MAX_FEATURES + 32'(f_q))];
    coef_rd_q <= coef_mem[CoefW'(32'(coef_row) * MAX_SV + 32'(s_q))];
    kern_rd_q <= kern_mem[SvW'(s_q)];
  end

  // Write kernels back
  always_ff @(posedge clk_i) begin
    if (state_q == ST_KERN_WR) kern_mem[SvW'(s_q)] <= exp_q;
  end

  // Exp table index: (gamma*dist + 2^29) >> 30
  logic [ProdW-1:0] idx_full;
  assign idx_full = (prod_q + (ProdW'(1) << 29)) >> 30;
  logic [15:0] exp_q;
  rbf_svm_exp_rom #(.EXP_ENTRIES(EXP_ENTRIES)) u_rom (
    .clk_i      (clk_i),
    .addr_i     (idx_full[ExpW-1:0]),
    .in_range_i (idx_full < ProdW'(EXP_ENTRIES)),
    .data_o     (exp_q)
  );

  // Decision value rounding and saturation
  logic signed [47:0] rnd;
  logic signed [43:0] q23;
  logic signed [31:0] dv;
  assign rnd = acc_q + 48'sd8;
  assign q23 = 44'(rnd >>> 4);
  assign dv  = (q23 > 44'sh7FFFFFFF) ? 32'sh7FFFFFFF :
               (q23 < -44'sh80000000) ? -32'sh80000000 : q23[31:0];

  logic signed [16:0] diff;
  assign diff = 17'(feat_mem[FtW'(f_q)]) - 17'(sv_rd_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && in_req_i.opcode == OP_FEAT && in_req_i.last)
        state_d = ST_DIST_RD;
      ST_DIST_RD:    state_d = ST_DIST_ACC;
      ST_DIST_ACC:   state_d = (f_q + 1'b1 >= nf) ? ST_KERN_MUL : ST_DIST_RD;
      ST_KERN_MUL:   state_d = ST_KERN_IDX;
      ST_KERN_IDX:   state_d = ST_KERN_WR;
      ST_KERN_WR:    state_d = (s_q + 1'b1 >= ns) ?
                               ((nc >= 2) ? ST_PAIR_START : ST_FINAL_SCAN) : ST_DIST_RD;
      ST_PAIR_START: state_d = (c0 < c1) ? ST_PAIR_RD :
                               (side_q ? ST_PAIR_EMIT : ST_PAIR_START);
      ST_PAIR_RD:    state_d = ST_PAIR_MAC;
      ST_PAIR_MAC:   state_d = (s_q < lim_q) ? ST_PAIR_RD :
                               (side_q ? ST_PAIR_EMIT : ST_PAIR_START);
      ST_PAIR_EMIT:  if (out_free)
        state_d = (n_q + 1'b1 < nc || m_q + 2'd2 < nc) ? ST_PAIR_START : ST_FINAL_SCAN;
      ST_FINAL_SCAN: state_d = (m_q + 1'b1 >= nc) ? ST_FINAL_EMIT : ST_FINAL_SCAN;
      ST_FINAL_EMIT: if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Datapath sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0; f_q <= '0; dist_q <= '0; prod_q <= '0;
      m_q <= '0; n_q <= '0; p_q <= '0; side_q <= 1'b0; lim_q <= '0;
      acc_q <= '0; best_q <= '0;
      out_vld_q <= 1'b0; out_q <= '0;
      for (int c = 0; c < MAX_CLASSES; c++) votes_q[c] <= '0;
    end else begin
      if (out_vld_q && !out_stall_i && !emit) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          s_q <= '0; f_q <= '0; dist_q <= '0;
          m_q <= '0; n_q <= ClCW'(1); p_q <= '0; side_q <= 1'b0;
          for (int c = 0; c < MAX_CLASSES; c++) votes_q[c] <= '0;
        end
        ST_DIST_ACC: begin
          if (f_q < nf) dist_q <= dist_q + DistW'($unsigned(34'(diff * diff)));
          f_q    <= f_q + 1'b1;
        end
        ST_KERN_MUL: prod_q <= ProdW'(gamma_q) * ProdW'(dist_q);
        ST_KERN_WR: begin
          s_q    <= s_q + 1'b1;
          f_q    <= '0;
          dist_q <= '0;
        end
        ST_PAIR_START: begin
          if (!side_q) acc_q <= 48'(icpt_mem[p_q]) <<< 15;
          s_q   <= c0;
          lim_q <= c1;
          // Empty range: move on to the n side, or emit when it was the n side
          if (!(c0 < c1)) side_q <= 1'b1;
        end
        ST_PAIR_RD: s_q <= s_q + 1'b1;
        ST_PAIR_MAC: begin
          acc_q <= acc_q + 48'($signed({1'b0, kern_rd_q}) * coef_rd_q);
          if (!(s_q < lim_q) && !side_q) side_q <= 1'b1;
        end
        ST_PAIR_EMIT: if (out_free) begin
          out_q.kind <= 1'b0;
          out_q.pair_index <= 5'(p_q);
          out_q.pair_score <= dv;
          out_q.predicted_class <= '0;
          out_q.vote_count <= '0;
          out_q.end_of_run <= 1'b0;
          out_vld_q <= 1'b1;
          if (dv > 0) votes_q[ClW'(m_q)] <= votes_q[ClW'(m_q)] + 1'b1;
          else        votes_q[ClW'(n_q)] <= votes_q[ClW'(n_q)] + 1'b1;
          p_q    <= p_q + 1'b1;
          side_q <= 1'b0;
          if (n_q + 1'b1 < nc) n_q <= n_q + 1'b1;
          else if (m_q + 2'd2 < nc) begin
            m_q <= m_q + 1'b1;
            n_q <= m_q + 2'd2;
          end else begin
            m_q <= '0;
          end
        end
        ST_FINAL_SCAN: begin
          if (m_q == '0) best_q <= '0;
          else if (votes_q[ClW'(m_q)] > votes_q[ClW'(best_q)]) best_q <= m_q;
          m_q <= m_q + 1'b1;
        end
        ST_FINAL_EMIT: if (out_free) begin
          out_q.kind <= 1'b1;
          out_q.pair_index <= '0;
          out_q.pair_score <= '0;
          out_q.predicted_class <= 3'(best_q);
          out_q.vote_count <= (nc >= 2) ? votes_q[ClW'(best_q)] : 3'd0;
          out_q.end_of_run <= 1'b1;
          out_vld_q <= 1'b1;
        end
        default: ;
      endcase
      if (state_q == ST_KERN_WR && state_d == ST_FINAL_SCAN) m_q <= '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

  // Assertions
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (state_q == ST_IDLE)) else $error("config ready while busy");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> $stable(out_q)) else $error("result changed");
  a_end_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.kind == out_q.end_of_run)) else $error("kind mismatch");

endmodule

// ===== tb/sv/rbf_svm_ovo_classifier_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RBF SVM one-vs-one classifier testbench
// Loads stores and streams features through the request channel, predicts
// every pair decision and final vote in fixed point, and checks each output
// request against the oldest prediction under varying idle and stall rates.
// ----------------------------------------------------------------------------
module rbf_svm_ovo_classifier_top_tb;
  import rbf_svm_pkg::*;

  localparam int unsigned NSv     = 64;
  localparam int unsigned NFeat   = 16;
  localparam int unsigned NClass  = 8;
  localparam int unsigned NPairs  = NClass * (NClass - 1) / 2;
  localparam int unsigned NExp    = 1024;
  localparam longint unsigned ExpStep = 64'd4228380000;
  localparam int unsigned CycleLimit  = 2000000;
  localparam logic [2:0] OpRsvdFirst = 3'd5;
  localparam logic [2:0] OpRsvdLast  = 3'd7;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_req_t out_req_o;
  logic     cfg_valid_i = 1'b0;
  logic     cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  rbf_svm_ovo_classifier_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_req_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: registers and stores as the block sees them
  logic [15:0] exp_tab [NExp];
  logic [15:0] gamma_r;
  logic [6:0]  sv_cnt_r;
  logic [4:0]  feat_cnt_r;
  logic [3:0]  class_cnt_r;
  logic signed [15:0] sv_mem   [NSv*NFeat];
  logic signed [15:0] coef_mem [(NClass-1)*NSv];
  logic signed [15:0] icpt_mem [NPairs];
  logic [6:0]         cstart_mem [NClass+1];
  logic signed [15:0] feat_mem [NFeat];

  in_req_t  pending_reqs[$];
  out_req_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned gen_items = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  function automatic int clamp_cnt(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  // Run one classification on the predictor copy and queue its results
  task automatic classify_sample();
    int ns, nf, nc, p, a0, a1, b0, b1, best, kval;
    longint unsigned sq_sum, idx;
    longint d, acc, t, q;
    logic [15:0] kern [NSv];
    logic [2:0] votes [NClass];
    logic signed [31:0] dv;
    out_req_t res;
    ns = clamp_cnt(sv_cnt_r, NSv);
    nf = clamp_cnt(feat_cnt_r, NFeat);
    nc = clamp_cnt(class_cnt_r, NClass);
    for (int s = 0; s < ns; s++) begin
      sq_sum = 0;
      for (int f = 0; f < nf; f++) begin
        d = longint'(feat_mem[f]) - longint'(sv_mem[s*NFeat+f]);
        sq_sum += longint'(d * d);
      end
      idx = (longint'(gamma_r) * sq_sum + (64'd1 << 29)) >> 30;
      kern[s] = (idx < NExp) ? exp_tab[idx] : 16'd0;
    end
    for (int c = 0; c < NClass; c++) votes[c] = '0;
    p = 0;
    for (int m = 0; m + 1 < nc; m++) begin
      for (int n = m + 1; n < nc; n++) begin
        acc = longint'(icpt_mem[p]) * 32768;
        a0 = clamp_cnt(cstart_mem[m], ns);
        a1 = clamp_cnt(cstart_mem[m+1], ns);
        b0 = clamp_cnt(cstart_mem[n], ns);
        b1 = clamp_cnt(cstart_mem[n+1], ns);
        for (int s = a0; s < a1; s++) begin
          kval = kern[s];
          acc += longint'(kval) * longint'(coef_mem[(n-1)*NSv+s]);
        end
        for (int s = b0; s < b1; s++) begin
          kval = kern[s];
          acc += longint'(kval) * longint'(coef_mem[m*NSv+s]);
        end
        t = acc + 8;
        q = t >>> 4;
        if (q > 64'sd2147483647) dv = 32'sh7fffffff;
        else if (q < -64'sd2147483648) dv = 32'sh80000000;
        else dv = q[31:0];
        if (dv > 0) votes[m] = votes[m] + 3'd1;
        else votes[n] = votes[n] + 3'd1;
        res = '0;
        res.pair_index = p[4:0];
        res.pair_score = dv;
        expected_results.push_back(res);
        p++;
      end
    end
    best = 0;
    for (int c = 1; c < nc; c++)
      if (votes[c] > votes[best]) best = c;
    res = '0;
    res.kind = 1'b1;
    res.predicted_class = best[2:0];
    res.vote_count = (nc >= 2) ? votes[best] : 3'd0;
    res.end_of_run = 1'b1;
    expected_results.push_back(res);
  endtask

  // Apply one accepted request to the predictor copy
  task automatic apply_request(in_req_t r);
    case (r.opcode)
      OP_SV:
        if (r.column_index < NFeat) sv_mem[r.row_index*NFeat+r.column_index] = r.value;
      OP_COEF:
        if (r.row_index < NClass - 1) coef_mem[r.row_index*NSv+r.column_index] = r.value;
      OP_ICPT:
        if (r.row_index < NPairs) icpt_mem[r.row_index] = r.value;
      OP_CSTART:
        if (r.row_index <= NClass) cstart_mem[r.row_index] = r.value[6:0];
      OP_FEAT: begin
        if (r.column_index < NFeat) feat_mem[r.column_index] = r.value;
        if (r.last) classify_sample();
      end
      default: ;
    endcase
  endtask

  // Driver: hold a stalled request, advance on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) apply_request(in_req_i);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each accepted result request
  always @(posedge clk_i or negedge rst_ni) begin
    out_req_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result request kind=%0d", out_req_o.kind);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_req_o.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_req_o.kind);
            errors++;
          end
          if (out_req_o.pair_index !== want.pair_index) begin
            $error("pair_index: expected %0d, actual %0d", want.pair_index,
                   out_req_o.pair_index);
            errors++;
          end
          if (out_req_o.pair_score !== want.pair_score) begin
            $error("pair_score: expected %0d, actual %0d", want.pair_score,
                   out_req_o.pair_score);
            errors++;
          end
          if (out_req_o.predicted_class !== want.predicted_class) begin
            $error("predicted_class: expected %0d, actual %0d", want.predicted_class,
                   out_req_o.predicted_class);
            errors++;
          end
          if (out_req_o.vote_count !== want.vote_count) begin
            $error("vote_count: expected %0d, actual %0d", want.vote_count,
                   out_req_o.vote_count);
            errors++;
          end
          if (out_req_o.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0d, actual %0d", want.end_of_run,
                   out_req_o.end_of_run);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(logic [2:0] op, int row, int col, logic [15:0] val, logic last);
    in_req_t r;
    r.opcode = op;
    r.row_index = row[5:0];
    r.column_index = col[5:0];
    r.value = val;
    r.last = last;
    pending_reqs.push_back(r);
    gen_items++;
  endtask

  // Noise requests: reserved opcodes, out-of-range loads and plain feature writes
  task automatic push_noise();
    logic [15:0] v;
    v = 16'($urandom());
    case ($urandom_range(0, 5))
      0: push_req(3'($urandom_range(OpRsvdFirst, OpRsvdLast)), $urandom_range(0, 63),
                  $urandom_range(0, 63), v, 1'($urandom()));
      1: push_req(OP_SV, $urandom_range(0, 63), $urandom_range(16, 63), v, 1'($urandom()));
      2: push_req(OP_COEF, $urandom_range(7, 63), $urandom_range(0, 63), v, 1'b0);
      3: push_req(OP_ICPT, $urandom_range(28, 63), $urandom_range(0, 63), v, 1'b1);
      4: push_req(OP_CSTART, $urandom_range(9, 63), $urandom_range(0, 63), v, 1'b0);
      default: push_req(OP_FEAT, $urandom_range(0, 63), $urandom_range(0, 63), v, 1'b0);
    endcase
  endtask

  function automatic logic [15:0] near_value();
    if ($urandom_range(0, 9) < 7) return 16'($urandom_range(0, 2047) - 1024);
    return 16'($urandom());
  endfunction

  // vmode: 0 random, 1 all max, 2 all min
  function automatic logic [15:0] weight_value(int vmode);
    if (vmode == 1) return 16'h7fff;
    if (vmode == 2) return 16'h8000;
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Load every entry the current setting reads, then stream one feature vector
  task automatic gen_case(int vmode);
    int ns, nf, nc, np;
    ns = clamp_cnt(sv_cnt_r, NSv);
    nf = clamp_cnt(feat_cnt_r, NFeat);
    nc = clamp_cnt(class_cnt_r, NClass);
    np = (nc >= 2) ? nc * (nc - 1) / 2 : 0;
    for (int s = 0; s < ns; s++)
      for (int f = 0; f < nf; f++) begin
        push_req(OP_SV, s, f, near_value(), ($urandom_range(0, 7) == 0));
        if ($urandom_range(0, 19) == 0) push_noise();
      end
    for (int m = 0; m + 1 < nc; m++)
      for (int s = 0; s < ns; s++) push_req(OP_COEF, m, s, weight_value(vmode), 1'b0);
    for (int p = 0; p < np; p++) push_req(OP_ICPT, p, $urandom_range(0, 63),
                                          weight_value(vmode), 1'b0);
    for (int c = 0; c <= nc; c++) begin
      if ($urandom_range(0, 4) == 0)
        push_req(OP_CSTART, c, 0, 16'($urandom()), 1'b0);
      else
        push_req(OP_CSTART, c, 0, 16'((c * ns) / ((nc > 0) ? nc : 1)) | 16'hff80, 1'b0);
    end
    for (int f = 0; f < nf; f++) begin
      if ($urandom_range(0, 19) == 0) push_noise();
      push_req(OP_FEAT, 0, f, near_value(), (f == nf - 1) && ($urandom_range(0, 5) != 0));
    end
    // classification may also start from an index past the buffer
    if (pending_reqs[pending_reqs.size()-1].last == 1'b0)
      push_req(OP_FEAT, $urandom_range(0, 63), $urandom_range(16, 63), 16'($urandom()), 1'b1);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_index_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      REG_GAMMA:  gamma_r     = data;
      REG_SV_CNT: sv_cnt_r    = data[6:0];
      REG_FT_CNT: feat_cnt_r  = data[4:0];
      REG_CL_CNT: class_cnt_r = data[3:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int g, int svc, int fc, int cc, int ncases, int mode, int vmode);
    wait_idle();
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
    cfg_write(REG_GAMMA, 16'(g));
    cfg_write(REG_SV_CNT, 16'(svc));
    cfg_write(REG_FT_CNT, 16'(fc));
    cfg_write(REG_CL_CNT, 16'(cc));
    for (int k = 0; k < ncases; k++) gen_case(vmode);
  endtask

  initial begin
    longint unsigned acc;
    int ph;
    acc = 64'd1 << 32;
    for (int i = 0; i < NExp; i++) begin
      exp_tab[i] = 16'((acc + (64'd1 << 16)) >> 17);
      acc = (acc * ExpStep + (64'd1 << 31)) >> 32;
    end
    gamma_r = 16'd4096;
    sv_cnt_r = 7'd64;
    feat_cnt_r = 5'd16;
    class_cnt_r = 4'd2;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme gamma and sizes, single class, saturation both ways
    run_phase(65535, 1, 1, 2, 1, 0, 0);
    run_phase(4096, 3, 2, 1, 1, 1, 0);
    run_phase(0, 6, 2, 3, 1, 2, 1);
    run_phase(0, 6, 2, 3, 1, 3, 2);
    // Counts above the maxima clamp
    run_phase(0, 127, 1, 2, 1, 2, 0);
    run_phase(0, 1, 31, 15, 1, 1, 0);

    // Random settings across the idling modes
    ph = 0;
    while (gen_items < 320) begin
      run_phase($urandom_range(0, 16383), $urandom_range(1, 8), $urandom_range(1, 4),
                $urandom_range(2, 5), $urandom_range(1, 2), ph % 4, 0);
      ph++;
    end
    run_phase(4096, 4, 3, 8, 1, 3, 0);

    wait_idle();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
